### sv/dmr_pkg.sv
// package for the deterministic miller-rabin tester
// holds the default word width and the base tables; no dependencies
`timescale 1ns / 1ps

package dmr_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int BASE_W        = 6;
	localparam int IDX_W         = 4;
	localparam logic [IDX_W-1:0] NUM_BASES_SMALL = 4'd3;
	localparam logic [IDX_W-1:0] NUM_BASES_LARGE = 4'd10;

	// witness base for a given index; small set is 2, 7, 61
	function automatic logic [BASE_W-1:0] base_value(input logic [IDX_W-1:0] idx,
		input logic large_set);
		logic [BASE_W-1:0] v;
		v = '0;
		if (!large_set) begin
			unique case (idx)
				4'd0: v = 6'd2;
				4'd1: v = 6'd7;
				4'd2: v = 6'd61;
				default: v = 6'd2;
			endcase
		end else begin
			unique case (idx)
				4'd0: v = 6'd2;
				4'd1: v = 6'd3;
				4'd2: v = 6'd5;
				4'd3: v = 6'd7;
				4'd4: v = 6'd11;
				4'd5: v = 6'd13;
				4'd6: v = 6'd17;
				4'd7: v = 6'd19;
				4'd8: v = 6'd23;
				4'd9: v = 6'd29;
				default: v = 6'd2;
			endcase
		end
		return v;
	endfunction

endpackage

### sv/dmr_mulmod.sv
// bit-serial modular multiplier: p = x*y mod m, one multiplier bit per doubling step and add step
// depends on dmr_pkg
`timescale 1ns / 1ps

module dmr_mulmod
	import dmr_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] x,
	input  logic [WORD_BITS-1:0] y,
	input  logic [WORD_BITS-1:0] m,
	output logic                 done,
	output logic [WORD_BITS-1:0] p
);

	localparam int CNT_W = $clog2(WORD_BITS + 1);

	logic                 busy_q;
	logic                 phase_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [WORD_BITS-1:0] acc_q;
	logic [WORD_BITS-1:0] x_q;
	logic [WORD_BITS-1:0] y_q;
	logic [WORD_BITS-1:0] m_q;
	logic [WORD_BITS-1:0] addend;
	logic [WORD_BITS:0]   sum;
	logic [WORD_BITS-1:0] sum_red;

	// one modular add: doubling in phase 0, adding x in phase 1
	assign addend  = phase_q ? x_q : acc_q;
	assign sum     = {1'b0, acc_q} + {1'b0, addend};
	assign sum_red = (sum >= {1'b0, m_q}) ? WORD_BITS'(sum - {1'b0, m_q})
	                                      : sum[WORD_BITS-1:0];

	// control of the serial walk over y, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CNT_W'(WORD_BITS);
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
		end else if (busy_q) begin
			if (!phase_q) begin
				acc_q <= sum_red;
			end else begin
				if (y_q[WORD_BITS-1])
					acc_q <= sum_red;
				y_q <= {y_q[WORD_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign p    = acc_q;

endmodule

### sv/deterministic_miller_rabin_tester_top.sv
// top level of the deterministic miller-rabin primality tester
// depends on dmr_pkg and dmr_mulmod
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid, in_stall, candidate) takes one WORD_BITS-wide
// word; the output channel (out_valid, out_stall, is_prime) returns one bit per
// item, in order. An item is taken when valid is high and stall is low.
// Even words and odd words below 2^(WORD_BITS-1)-1 skip the test; their result
// goes to the output register without any multiply.
// Other words run a strong probable-prime test per base (3 bases at 32 bits,
// 10 otherwise). Each modular multiply is done in the shared bit-serial unit,
// and a base needs up to about 2*WORD_BITS multiplies; a failing base ends the
// test early.
// One item is worked on at a time; in_stall is high while busy. The result sits
// in an output register, so a new item is taken while it waits; a finished test
// holds until the output register is free. Reset clears all control state and
// drops out_valid.

module deterministic_miller_rabin_tester_top
	import dmr_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [WORD_BITS-1:0] candidate,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 is_prime
);

	localparam int S_W = $clog2(WORD_BITS);
	localparam logic LARGE = (WORD_BITS != 32);
	localparam logic [IDX_W-1:0] NUM_BASES = LARGE ? NUM_BASES_LARGE : NUM_BASES_SMALL;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_INIT  = 9'b000000010,
		ST_SPLIT = 9'b000000100,
		ST_POW   = 9'b000001000,
		ST_PMUL  = 9'b000010000,
		ST_PSQR  = 9'b000100000,
		ST_SQ    = 9'b001000000,
		ST_SQW   = 9'b010000000,
		ST_NEXT  = 9'b100000000
	} state_t;

	state_t               state_q;
	logic                 finish_q;
	logic                 verdict_q;
	logic                 out_valid_q;
	logic                 is_prime_q;
	logic [IDX_W-1:0]     idx_q;
	logic [S_W-1:0]       s_q;
	logic [WORD_BITS-1:0] m_q;
	logic [WORD_BITS-1:0] e_q;
	logic [WORD_BITS-1:0] res_q;
	logic [WORD_BITS-1:0] b_q;
	logic [WORD_BITS-1:0] base_ext;
	logic [WORD_BITS-1:0] m_minus1;
	logic [WORD_BITS-1:0] thresh;

	logic                 mm_start;
	logic                 mm_done;
	logic [WORD_BITS-1:0] mm_x;
	logic [WORD_BITS-1:0] mm_y;
	logic [WORD_BITS-1:0] mm_p;
	logic                 iss_rb;
	logic                 iss_bb;
	logic                 iss_tt;
	logic                 out_free;

	assign base_ext = WORD_BITS'(base_value(idx_q, LARGE));
	assign m_minus1 = m_q - 1'b1;
	assign thresh   = {1'b0, {(WORD_BITS-1){1'b1}}};
	assign out_free = !out_valid_q || !out_stall;

	// multiply issue: res*b, b*b, or t*t (t lives in res_q)
	assign iss_rb = (state_q == ST_POW) && (e_q != '0) && e_q[0];
	assign iss_bb = ((state_q == ST_POW) && (e_q != '0) && !e_q[0])
	             || ((state_q == ST_PMUL) && mm_done);
	assign iss_tt = (state_q == ST_SQ) && (s_q != '0) && (res_q != m_minus1);
	assign mm_start = iss_rb || iss_bb || iss_tt;
	assign mm_x = iss_bb ? b_q : res_q;
	assign mm_y = iss_rb ? b_q : (iss_bb ? b_q : res_q);

	dmr_mulmod #(
		.WORD_BITS(WORD_BITS)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mm_start),
		.x     (mm_x),
		.y     (mm_y),
		.m     (m_q),
		.done  (mm_done),
		.p     (mm_p)
	);

	// test sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			finish_q <= 1'b0;
			idx_q    <= '0;
			s_q      <= '0;
		end else begin
			if (finish_q) begin
				if (out_free)
					finish_q <= 1'b0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (in_valid) begin
							idx_q <= '0;
							if (!candidate[0] || candidate < thresh)
								finish_q <= 1'b1;
							else
								state_q <= ST_INIT;
						end
					end
					ST_INIT: begin
						s_q <= '0;
						if (base_ext == m_q)
							state_q <= ST_NEXT;
						else
							state_q <= ST_SPLIT;
					end
					ST_SPLIT: begin
						if (!e_q[0])
							s_q <= s_q + 1'b1;
						else
							state_q <= ST_POW;
					end
					ST_POW: begin
						if (e_q == '0) begin
							if (res_q == WORD_BITS'(1))
								state_q <= ST_NEXT;
							else
								state_q <= ST_SQ;
						end else if (e_q[0]) begin
							state_q <= ST_PMUL;
						end else begin
							state_q <= ST_PSQR;
						end
					end
					ST_PMUL: begin
						if (mm_done)
							state_q <= ST_PSQR;
					end
					ST_PSQR: begin
						if (mm_done)
							state_q <= ST_POW;
					end
					ST_SQ: begin
						if (s_q == '0) begin
							state_q  <= ST_IDLE;
							finish_q <= 1'b1;
						end else if (res_q == m_minus1) begin
							state_q <= ST_NEXT;
						end else begin
							state_q <= ST_SQW;
						end
					end
					ST_SQW: begin
						if (mm_done) begin
							s_q     <= s_q - 1'b1;
							state_q <= ST_SQ;
						end
					end
					ST_NEXT: begin
						if (idx_q == NUM_BASES - 1'b1) begin
							state_q  <= ST_IDLE;
							finish_q <= 1'b1;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_INIT;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (!finish_q) begin
			case (state_q)
				ST_IDLE: begin
					m_q       <= candidate;
					verdict_q <= candidate[0];
				end
				ST_INIT: begin
					e_q       <= m_minus1;
					res_q     <= WORD_BITS'(1);
					b_q       <= base_ext;
					verdict_q <= 1'b1;
				end
				ST_SPLIT: begin
					if (!e_q[0])
						e_q <= {1'b0, e_q[WORD_BITS-1:1]};
				end
				ST_PMUL: begin
					if (mm_done)
						res_q <= mm_p;
				end
				ST_PSQR: begin
					if (mm_done) begin
						b_q <= mm_p;
						e_q <= {1'b0, e_q[WORD_BITS-1:1]};
					end
				end
				ST_SQ: begin
					if (s_q == '0)
						verdict_q <= 1'b0;
				end
				ST_SQW: begin
					if (mm_done)
						res_q <= mm_p;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (finish_q && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_q && out_free)
			is_prime_q <= verdict_q;
	end

	assign in_stall  = (state_q != ST_IDLE) || finish_q;
	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

endmodule

### dv/deterministic_miller_rabin_tester_top_test.sv
// testbench for the deterministic miller-rabin primality tester top level
// predicts each verdict with its own strong probable-prime test; depends on dmr_pkg
`timescale 1ns / 1ps

module deterministic_miller_rabin_tester_top_test;
	import dmr_pkg::*;

	localparam int W = WORD_BITS_DEF;
	localparam int CYCLE_LIMIT = 10000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [W-1:0] candidate;
	logic out_valid;
	logic out_stall = 1'b0;
	logic is_prime;

	bit verdict_q[$];
	int fails = 0;
	int cycles = 0;
	bit idle_free;
	bit hold_go;
	bit hold_off;

	deterministic_miller_rabin_tester_top u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.candidate(candidate), .out_valid(out_valid), .out_stall(out_stall),
		.is_prime(is_prime)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// (x*y) mod m through a wide product
	function automatic logic [63:0] mod_mul(input logic [63:0] x, input logic [63:0] y,
		input logic [63:0] m);
		logic [127:0] p;
		p = x * y;
		return 64'(p % m);
	endfunction

	// strong probable-prime test of m to base a
	function automatic bit spp_pass(input logic [63:0] a, input logic [63:0] m);
		logic [63:0] e;
		logic [63:0] t;
		logic [63:0] b;
		int s;
		if (a == m) return 1'b1;
		e = m - 1;
		s = 0;
		while (e != 0 && e[0] == 1'b0) begin
			e = e >> 1;
			s++;
		end
		t = 1 % m;
		b = a % m;
		while (e != 0) begin
			if (e[0]) t = mod_mul(t, b, m);
			b = mod_mul(b, b, m);
			e = e >> 1;
		end
		if (t == 1) return 1'b1;
		for (int r = 0; r < s; r++) begin
			if (t == m - 1) return 1'b1;
			t = mod_mul(t, t, m);
		end
		return 1'b0;
	endfunction

	// expected verdict for one candidate
	function automatic bit primality(input logic [W-1:0] c);
		logic [63:0] x;
		logic [63:0] mask;
		x = 64'(c);
		mask = 64'(1) << (W - 1);
		mask = mask - 1;
		if (!x[0]) return 1'b0;
		if (x < mask) return 1'b1;
		return spp_pass(2, x) && spp_pass(7, x) && spp_pass(61, x);
	endfunction

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		fails++;
	endtask

	// send one item, with random idle cycles; valid stays up until the next call
	task automatic send_item(input logic [W-1:0] c);
		while (!idle_free && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		candidate <= c;
		verdict_q.push_back(primality(c));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// long receiver hold-off, counted in cycles
	initial begin
		hold_off = 1'b0;
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	// receiver stalls and result check
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					report("result with none expected");
				end else begin
					bit exp_v;
					exp_v = verdict_q.pop_front();
					if (is_prime !== exp_v)
						report($sformatf("is_prime %b expected %b", is_prime, exp_v));
				end
			end
			out_stall <= hold_off || (!idle_free && ($urandom_range(99) < 13));
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("deterministic_miller_rabin_tester_top_test NOT OK");
			$finish;
		end
	end

	// random odd word with the top bit set, so the full test runs
	function automatic logic [W-1:0] top_odd();
		return W'($urandom) | {1'b1, {(W-2){1'b0}}, 1'b1};
	endfunction

	task automatic test_directed();
		logic [W-1:0] words[$];
		words = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
			32'h7FFF_FFFF, 32'h7FFF_FFFD, 32'h8000_0000, 32'h8000_0001,
			32'h8000_000B, 32'd4294967291, 32'd4294967279, 32'd4294967295,
			32'hAAAA_AAAB, 32'h5555_5555, 32'd3215031751, 32'd2147483659,
			32'd4294967197, 32'h8000_0003};
		foreach (words[i]) send_item(words[i]);
	endtask

	task automatic test_random();
		for (int i = 0; i < 100; i++) begin
			if ($urandom_range(3) == 0) send_item(W'($urandom));
			else send_item(top_odd());
		end
	endtask

	task automatic test_quiet();
		idle_free = 1'b1;
		for (int i = 0; i < 12; i++) send_item(top_odd());
		idle_free = 1'b0;
	endtask

	// receiver holds off while small items keep coming
	task automatic test_backpressure();
		hold_go = 1'b1;
		for (int i = 0; i < 8; i++) send_item(W'($urandom_range(1000)));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		candidate = '0;
		idle_free = 1'b0;
		hold_go = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_quiet();
		test_random();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fails == 0) begin
			$display("deterministic_miller_rabin_tester_top_test OK");
		end else begin
			$display("deterministic_miller_rabin_tester_top_test NOT OK");
		end
		$finish;
	end

endmodule
